### hdl/look_at_view_matrix_core_defines.svh
// Assertion macros shared by the view matrix core modules.
`ifndef LOOK_AT_VIEW_MATRIX_CORE_DEFINES_SVH
`define LOOK_AT_VIEW_MATRIX_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define LVM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("view matrix core: property failed");
`define LVM_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("view matrix core: forbidden condition");
`else
`define LVM_ASSERT(lbl, prop)
`define LVM_ASSERT_NEVER(lbl, cond)
`endif
`endif

### hdl/lvm_pkg.sv
// Shared types, constants and helpers of the view matrix core.
package lvm_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int IQ_DEPTH = 2;
  localparam int OQ_DEPTH = 4;
  localparam int NORM_HI = 30;
  localparam int NORM_LO = 29;
  localparam int MAG_W = 30;
  localparam int SUM_W = 62;
  localparam int ROOT_W = 63;
  localparam int N_W = 31;

  typedef struct packed {
    logic [2:0][31:0] eye;
    logic [2:0][31:0] upv;
    logic [2:0][32:0] dif;
  } cam_t;

  typedef struct packed {
    logic [1:0]  row_index;
    logic [31:0] e0;
    logic [31:0] e1;
    logic [31:0] e2;
    logic [31:0] e3;
    logic [7:0]  rr;
    logic [7:0]  ru;
    logic        degenerate;
    logic        last_row;
  } row_t;

  typedef struct packed {
    logic done;
    logic zero;
  } unit_sts_t;

  function automatic logic [1:0] nxt3(input logic [1:0] i);
    case (i)
      2'd0:    nxt3 = 2'd1;
      2'd1:    nxt3 = 2'd2;
      default: nxt3 = 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] prv3(input logic [1:0] i);
    case (i)
      2'd0:    prv3 = 2'd2;
      2'd1:    prv3 = 2'd0;
      default: prv3 = 2'd1;
    endcase
  endfunction
endpackage

### hdl/look_at_view_matrix_core.sv
// Top level of the camera view matrix core.
//
//   Channel   Handshake     Item
//   input     push / full   eye, target and up points of one camera
//   result    pop / empty   one matrix row, four rows per camera in order 0..3
//
// The time a camera takes is set by the shared normalizing unit, with the single-bit
// scaling shifts of its three vectors, its 32-step square root and its FRAC_BITS+1-step
// dividers, and by the row queue when rows do not drain freely. A zero-length vector
// ends a camera early.
// Reset clears all control state; no memory is swept after reset.
// full rises while two cameras are held, the one in work included; rows queue four
// deep and the sequencer holds when the row queue is full.
module look_at_view_matrix_core import lvm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] eye_x_i,
  input  logic signed [31:0] eye_y_i,
  input  logic signed [31:0] eye_z_i,
  input  logic signed [31:0] target_x_i,
  input  logic signed [31:0] target_y_i,
  input  logic signed [31:0] target_z_i,
  input  logic signed [31:0] upward_x_i,
  input  logic signed [31:0] upward_y_i,
  input  logic signed [31:0] upward_z_i,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         row_index_o,
  output logic signed [31:0] entry_zero_o,
  output logic signed [31:0] entry_one_o,
  output logic signed [31:0] entry_two_o,
  output logic signed [31:0] entry_three_o,
  output logic signed [7:0]  reflect_right_o,
  output logic signed [7:0]  reflect_up_o,
  output logic               degenerate_o,
  output logic               last_row_o
);
  cam_t                         head;
  logic                         head_valid;
  logic                         head_pop;
  logic                         ustart;
  logic signed [FRAC_BITS+33:0] uvec [3];
  unit_sts_t                    usts;
  logic signed [FRAC_BITS+1:0]  uout [3];
  logic                         oq_push;
  logic                         oq_full;
  row_t                         row_in;
  row_t                         row_out;

  lvm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .eye_x_i      (eye_x_i),
    .eye_y_i      (eye_y_i),
    .eye_z_i      (eye_z_i),
    .target_x_i   (target_x_i),
    .target_y_i   (target_y_i),
    .target_z_i   (target_z_i),
    .upward_x_i   (upward_x_i),
    .upward_y_i   (upward_y_i),
    .upward_z_i   (upward_z_i),
    .head_o       (head),
    .head_valid_o (head_valid),
    .pop_i        (head_pop)
  );

  lvm_unit #(.FRAC_BITS(FRAC_BITS)) u_unit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ustart),
    .vec_i   (uvec),
    .sts_o   (usts),
    .unit_o  (uout)
  );

  lvm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (head_pop),
    .ustart_o     (ustart),
    .uvec_o       (uvec),
    .usts_i       (usts),
    .unit_i       (uout),
    .oq_push_o    (oq_push),
    .row_o        (row_in),
    .oq_full_i    (oq_full)
  );

  lvm_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (oq_push),
    .row_i   (row_in),
    .full_o  (oq_full),
    .empty_o (empty),
    .pop_i   (pop),
    .row_o   (row_out)
  );

  assign row_index_o     = row_out.row_index;
  assign entry_zero_o    = row_out.e0;
  assign entry_one_o     = row_out.e1;
  assign entry_two_o     = row_out.e2;
  assign entry_three_o   = row_out.e3;
  assign reflect_right_o = row_out.rr;
  assign reflect_up_o    = row_out.ru;
  assign degenerate_o    = row_out.degenerate;
  assign last_row_o      = row_out.last_row;
endmodule

### hdl/lvm_front.sv
// Input queue that accepts camera items and forms the eye-to-target difference.
module lvm_front import lvm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [31:0] eye_x_i,
  input  logic [31:0] eye_y_i,
  input  logic [31:0] eye_z_i,
  input  logic [31:0] target_x_i,
  input  logic [31:0] target_y_i,
  input  logic [31:0] target_z_i,
  input  logic [31:0] upward_x_i,
  input  logic [31:0] upward_y_i,
  input  logic [31:0] upward_z_i,
  output cam_t        head_o,
  output logic        head_valid_o,
  input  logic        pop_i
);
  localparam int PW = $clog2(IQ_DEPTH);

  cam_t            mem_q [IQ_DEPTH];
  logic [PW-1:0]   wr_q;
  logic [PW-1:0]   rd_q;
  logic [PW:0]     cnt_q;
  cam_t            cam_d;
  logic            push_ok;
  logic            pop_ok;

  always_comb begin
    cam_d.eye    = {eye_z_i, eye_y_i, eye_x_i};
    cam_d.upv    = {upward_z_i, upward_y_i, upward_x_i};
    cam_d.dif[0] = {target_x_i[31], target_x_i} - {eye_x_i[31], eye_x_i};
    cam_d.dif[1] = {target_y_i[31], target_y_i} - {eye_y_i[31], eye_y_i};
    cam_d.dif[2] = {target_z_i[31], target_z_i} - {eye_z_i[31], eye_z_i};
  end

  assign full         = (cnt_q == (PW+1)'(IQ_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign push_ok      = push && !full;
  assign pop_ok       = pop_i && head_valid_o;
  assign head_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_q] <= cam_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_ok) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_ok) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_ok && !push_ok) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end
endmodule

### hdl/lvm_unit.sv
// Normalizing unit: power-of-two scaling, sum of squares, bit-serial root and division.
`include "look_at_view_matrix_core_defines.svh"
module lvm_unit import lvm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [FRAC_BITS+33:0] vec_i [3],
  output unit_sts_t                   sts_o,
  output logic signed [FRAC_BITS+1:0] unit_o [3]
);
  localparam int VW = FRAC_BITS + 34;
  localparam int QW = FRAC_BITS + 1;
  localparam int DW = MAG_W + FRAC_BITS + 1;
  localparam int CW = $clog2(FRAC_BITS + 1);
  localparam logic [VW-1:0] HI_LIM = VW'(1) << NORM_HI;
  localparam logic [VW-1:0] LO_LIM = VW'(1) << NORM_LO;

  typedef enum logic [2:0] {U_IDLE, U_NORM, U_SQ, U_ROOT, U_DIV} ustate_e;

  ustate_e               state_q;
  logic                  done_q;
  logic                  zero_q;
  logic                  neg_q [3];
  logic [VW-1:0]         mag_q [3];
  logic [VW-1:0]         m_q;
  logic [CW-1:0]         cnt_q;
  logic [2*MAG_W-1:0]    sq_q;
  logic [SUM_W-1:0]      x_q;
  logic [ROOT_W-1:0]     res_q;
  logic [ROOT_W-1:0]     bit_q;
  logic [DW-1:0]         dv_q;
  logic [DW-1:0]         rem_q [3];
  logic [QW-1:0]         q_q [3];

  logic [VW-1:0]         mag_s [3];
  logic [VW-1:0]         max_s;
  logic [ROOT_W-1:0]     rb;
  logic [ROOT_W-1:0]     res_n;
  logic                  take;
  logic [N_W-1:0]        n_n;
  logic [1:0]            sq_idx;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_s[i] = vec_i[i][VW-1] ? VW'(-vec_i[i]) : VW'(vec_i[i]);
    end
    max_s = mag_s[0];
    if (mag_s[1] > max_s) begin
      max_s = mag_s[1];
    end
    if (mag_s[2] > max_s) begin
      max_s = mag_s[2];
    end
    rb     = res_q + bit_q;
    take   = ({1'b0, x_q} >= rb);
    res_n  = take ? ((res_q >> 1) + bit_q) : (res_q >> 1);
    n_n    = res_n[N_W-1:0];
    sq_idx = (cnt_q == CW'(3)) ? 2'd0 : cnt_q[1:0];
    for (int i = 0; i < 3; i++) begin
      unit_o[i] = neg_q[i] ? -$signed({1'b0, q_q[i]}) : $signed({1'b0, q_q[i]});
    end
  end

  assign sts_o.done = done_q;
  assign sts_o.zero = zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      done_q  <= 1'b0;
      zero_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        U_IDLE: begin
          if (start_i) begin
            for (int i = 0; i < 3; i++) begin
              neg_q[i] <= vec_i[i][VW-1];
              mag_q[i] <= mag_s[i];
            end
            m_q <= max_s;
            if (max_s == '0) begin
              done_q <= 1'b1;
              zero_q <= 1'b1;
            end else begin
              state_q <= U_NORM;
            end
          end
        end
        U_NORM: begin
          if (m_q >= HI_LIM) begin
            m_q <= m_q >> 1;
            for (int i = 0; i < 3; i++) begin
              mag_q[i] <= mag_q[i] >> 1;
            end
          end else if (m_q < LO_LIM) begin
            m_q <= m_q << 1;
            for (int i = 0; i < 3; i++) begin
              mag_q[i] <= mag_q[i] << 1;
            end
          end else begin
            state_q <= U_SQ;
            cnt_q   <= '0;
            x_q     <= '0;
          end
        end
        U_SQ: begin
          if (cnt_q != CW'(3)) begin
            sq_q <= mag_q[sq_idx][MAG_W-1:0] * mag_q[sq_idx][MAG_W-1:0];
          end
          if (cnt_q != '0) begin
            x_q <= x_q + SUM_W'(sq_q);
          end
          if (cnt_q == CW'(3)) begin
            state_q <= U_ROOT;
            res_q   <= '0;
            bit_q   <= ROOT_W'(1) << SUM_W;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        U_ROOT: begin
          if (take) begin
            x_q <= x_q - rb[SUM_W-1:0];
          end
          res_q <= res_n;
          bit_q <= bit_q >> 2;
          if (bit_q[0]) begin
            state_q <= U_DIV;
            cnt_q   <= CW'(FRAC_BITS);
            dv_q    <= DW'(n_n) << FRAC_BITS;
            for (int i = 0; i < 3; i++) begin
              rem_q[i] <= (DW'(mag_q[i][MAG_W-1:0]) << FRAC_BITS) + DW'(n_n >> 1);
              q_q[i]   <= '0;
            end
          end
        end
        U_DIV: begin
          for (int i = 0; i < 3; i++) begin
            if (rem_q[i] >= dv_q) begin
              rem_q[i] <= rem_q[i] - dv_q;
              q_q[i]   <= {q_q[i][QW-2:0], 1'b1};
            end else begin
              q_q[i] <= {q_q[i][QW-2:0], 1'b0};
            end
          end
          dv_q <= dv_q >> 1;
          if (cnt_q == '0) begin
            state_q <= U_IDLE;
            done_q  <= 1'b1;
            zero_q  <= 1'b0;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        default: state_q <= U_IDLE;
      endcase
    end
  end

  `LVM_ASSERT(a_done_single, sts_o.done |=> !sts_o.done)
  `LVM_ASSERT(a_start_when_idle, start_i |-> state_q == U_IDLE)
endmodule

### hdl/lvm_back.sv
// Sequencer that builds the basis vectors, dot products and matrix rows of one camera.
`include "look_at_view_matrix_core_defines.svh"
module lvm_back import lvm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cam_t                         head_i,
  input  logic                         head_valid_i,
  output logic                         pop_o,
  output logic                         ustart_o,
  output logic signed [FRAC_BITS+33:0] uvec_o [3],
  input  unit_sts_t                    usts_i,
  input  logic signed [FRAC_BITS+1:0]  unit_i [3],
  output logic                         oq_push_o,
  output row_t                         row_o,
  input  logic                         oq_full_i
);
  localparam int VW = FRAC_BITS + 34;
  localparam int UW = FRAC_BITS + 2;
  localparam int PW = 32 + UW;
  localparam int AW = PW + 2;
  localparam int RW = AW - FRAC_BITS;

  typedef enum logic [2:0] {
    B_IDLE, B_LOOK, B_X1, B_RIGHT, B_X2, B_TUP, B_DOT, B_EMIT
  } bstate_e;

  bstate_e               state_q;
  logic                  start_q;
  logic                  degen_q;
  logic [1:0]            row_q;
  logic signed [UW-1:0]  look_q [3];
  logic signed [UW-1:0]  right_q [3];
  logic signed [UW-1:0]  tup_q [3];
  logic signed [VW-1:0]  tmp_q [3];
  logic signed [AW-1:0]  dsum_q [3];
  logic                  issue_q;
  logic [1:0]            grp_q;
  logic [1:0]            trm_q;
  logic signed [PW-1:0]  p_q;
  logic                  pv_q;
  logic                  pfirst_q;
  logic                  plast_q;
  logic                  psub_q;
  logic [1:0]            pgrp_q;
  logic signed [AW-1:0]  acc_q;

  logic signed [31:0]    op_a;
  logic signed [UW-1:0]  op_b;
  logic                  op_sub;
  logic                  op_last;
  logic [1:0]            ia;
  logic [1:0]            ib;
  logic signed [AW-1:0]  p_ext;
  logic signed [AW-1:0]  acc_n;
  logic                  mac_end;

  function automatic logic [31:0] ndot(input logic signed [AW-1:0] s);
    logic          neg;
    logic [AW-1:0] m;
    logic [RW-1:0] r;
    logic [RW-1:0] rn;
    neg = s[AW-1];
    m   = neg ? AW'(-s) : AW'(s);
    m   = m + (AW'(1) << (FRAC_BITS - 1));
    r   = m[AW-1:FRAC_BITS];
    rn  = -r;
    if (neg) begin
      ndot = (r > RW'(32'h7fff_ffff)) ? 32'h7fff_ffff : r[31:0];
    end else begin
      ndot = (r > RW'(33'h0_8000_0000)) ? 32'h8000_0000 : rn[31:0];
    end
  endfunction

  function automatic logic [7:0] frac8(input logic signed [UW-1:0] u);
    logic          neg;
    logic [UW-1:0] m;
    logic [8:0]    t;
    logic [8:0]    tn;
    neg = u[UW-1];
    m   = neg ? UW'(-u) : UW'(u);
    t   = 9'(m >> (FRAC_BITS - 7));
    tn  = -t;
    if (neg) begin
      frac8 = tn[7:0];
    end else begin
      frac8 = (t > 9'd127) ? 8'd127 : t[7:0];
    end
  endfunction

  always_comb begin
    ia      = nxt3(grp_q);
    ib      = prv3(grp_q);
    op_a    = '0;
    op_b    = '0;
    op_sub  = 1'b0;
    op_last = trm_q[0];
    if (state_q == B_DOT) begin
      op_last = (trm_q == 2'd2);
      op_a    = $signed(head_i.eye[trm_q]);
      case (grp_q)
        2'd0:    op_b = right_q[trm_q];
        2'd1:    op_b = tup_q[trm_q];
        default: op_b = look_q[trm_q];
      endcase
    end else if (!trm_q[0]) begin
      op_a = (state_q == B_X1) ? $signed(head_i.upv[ia]) : 32'(look_q[ia]);
      op_b = (state_q == B_X1) ? look_q[ib] : right_q[ib];
    end else begin
      op_sub = 1'b1;
      op_a   = (state_q == B_X1) ? $signed(head_i.upv[ib]) : 32'(look_q[ib]);
      op_b   = (state_q == B_X1) ? look_q[ia] : right_q[ia];
    end
    p_ext   = AW'(p_q);
    acc_n   = (pfirst_q ? AW'(0) : acc_q) + (psub_q ? -p_ext : p_ext);
    mac_end = pv_q && plast_q && (pgrp_q == 2'd2);
  end

  always_comb begin
    row_o            = '0;
    row_o.row_index  = row_q;
    row_o.last_row   = (row_q == 2'd3);
    row_o.degenerate = degen_q;
    if (!degen_q) begin
      if (row_q != 2'd3) begin
        row_o.e0 = 32'(right_q[row_q]);
        row_o.e1 = 32'(tup_q[row_q]);
        row_o.e2 = 32'(look_q[row_q]);
        row_o.rr = frac8(right_q[row_q]);
        row_o.ru = frac8(tup_q[row_q]);
      end else begin
        row_o.e0 = ndot(dsum_q[0]);
        row_o.e1 = ndot(dsum_q[1]);
        row_o.e2 = ndot(dsum_q[2]);
        row_o.e3 = 32'(1) << FRAC_BITS;
      end
    end
    for (int i = 0; i < 3; i++) begin
      uvec_o[i] = (state_q == B_LOOK) ? VW'($signed(head_i.dif[i])) : tmp_q[i];
    end
  end

  assign ustart_o  = start_q;
  assign oq_push_o = (state_q == B_EMIT) && !oq_full_i;
  assign pop_o     = oq_push_o && (row_q == 2'd3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      start_q <= 1'b0;
      degen_q <= 1'b0;
      row_q   <= '0;
      issue_q <= 1'b0;
      pv_q    <= 1'b0;
      grp_q   <= '0;
      trm_q   <= '0;
    end else begin
      start_q <= 1'b0;
      if (issue_q) begin
        p_q      <= op_a * op_b;
        pv_q     <= 1'b1;
        pfirst_q <= (trm_q == 2'd0);
        plast_q  <= op_last;
        psub_q   <= op_sub;
        pgrp_q   <= grp_q;
        if (op_last) begin
          trm_q <= '0;
          if (grp_q == 2'd2) begin
            issue_q <= 1'b0;
          end else begin
            grp_q <= grp_q + 1'b1;
          end
        end else begin
          trm_q <= trm_q + 1'b1;
        end
      end else begin
        pv_q <= 1'b0;
      end
      if (pv_q) begin
        acc_q <= acc_n;
        if (plast_q) begin
          if (state_q == B_DOT) begin
            dsum_q[pgrp_q] <= acc_n;
          end else begin
            tmp_q[pgrp_q] <= VW'(acc_n);
          end
        end
      end
      unique case (state_q)
        B_IDLE: begin
          if (head_valid_i) begin
            state_q <= B_LOOK;
            start_q <= 1'b1;
            degen_q <= 1'b0;
          end
        end
        B_LOOK: begin
          if (usts_i.done) begin
            if (usts_i.zero) begin
              degen_q <= 1'b1;
              row_q   <= '0;
              state_q <= B_EMIT;
            end else begin
              for (int i = 0; i < 3; i++) begin
                look_q[i] <= -unit_i[i];
              end
              state_q <= B_X1;
              issue_q <= 1'b1;
              grp_q   <= '0;
              trm_q   <= '0;
            end
          end
        end
        B_X1: begin
          if (mac_end) begin
            state_q <= B_RIGHT;
            start_q <= 1'b1;
          end
        end
        B_RIGHT: begin
          if (usts_i.done) begin
            if (usts_i.zero) begin
              degen_q <= 1'b1;
              row_q   <= '0;
              state_q <= B_EMIT;
            end else begin
              right_q <= unit_i;
              state_q <= B_X2;
              issue_q <= 1'b1;
              grp_q   <= '0;
              trm_q   <= '0;
            end
          end
        end
        B_X2: begin
          if (mac_end) begin
            state_q <= B_TUP;
            start_q <= 1'b1;
          end
        end
        B_TUP: begin
          if (usts_i.done) begin
            if (usts_i.zero) begin
              degen_q <= 1'b1;
              row_q   <= '0;
              state_q <= B_EMIT;
            end else begin
              tup_q   <= unit_i;
              state_q <= B_DOT;
              issue_q <= 1'b1;
              grp_q   <= '0;
              trm_q   <= '0;
            end
          end
        end
        B_DOT: begin
          if (mac_end) begin
            row_q   <= '0;
            state_q <= B_EMIT;
          end
        end
        B_EMIT: begin
          if (!oq_full_i) begin
            row_q <= row_q + 1'b1;
            if (row_q == 2'd3) begin
              state_q <= B_IDLE;
            end
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  `LVM_ASSERT(a_unit_done_waiting,
    usts_i.done |-> (state_q == B_LOOK || state_q == B_RIGHT || state_q == B_TUP))
endmodule

### hdl/lvm_outq.sv
// Result queue that holds finished matrix rows until they are popped.
`include "look_at_view_matrix_core_defines.svh"
module lvm_outq import lvm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  row_t row_i,
  output logic full_o,
  output logic empty_o,
  input  logic pop_i,
  output row_t row_o
);
  localparam int PW = $clog2(OQ_DEPTH);

  row_t          mem_q [OQ_DEPTH];
  logic [PW-1:0] wr_q;
  logic [PW-1:0] rd_q;
  logic [PW:0]   cnt_q;
  logic          push_ok;
  logic          pop_ok;

  assign full_o  = (cnt_q == (PW+1)'(OQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;
  assign row_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_q] <= row_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_ok) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_ok) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_ok && !push_ok) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `LVM_ASSERT_NEVER(a_no_overflow, push_i && full_o)
endmodule
